/* hdl/ced_pkg.sv */
// Shared types and defaults for the C escape sequence decoder.
// No dependencies; imported by every module of the decoder.
package ced_pkg;

	// Default depth of the queue between the front and back parts
	localparam int QUEUE_DEPTH_DEF = 4;

	// One raw character of a literal body
	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_string;
	} item_t;

	// One decoded result
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_error;
		logic       is_last;
	} result_t;

	// Queue entry: the results of one character, first always present
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	// Front to queue write request
	typedef struct packed {
		logic   push;
		entry_t entry;
	} q_wr_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hdl/ced_front.sv */
// Front part: accepts characters, runs the escape state machine and
// classifies each character into zero, one or two results. Uses ced_pkg.
module ced_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  ced_pkg::item_t    item,
	input  ced_pkg::q_stat_t  q_stat,
	output logic              item_stall,
	output ced_pkg::q_wr_t    q_wr
);
	import ced_pkg::*;

	typedef enum logic [5:0] {
		MODE_PLAIN   = 6'b000001,
		MODE_ESC     = 6'b000010,
		MODE_OCT     = 6'b000100,
		MODE_HEXF    = 6'b001000,
		MODE_HEX     = 6'b010000,
		MODE_DISCARD = 6'b100000
	} mode_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;

	// Single-character escape lookup: {hit, byte}
	function automatic logic [8:0] single_escape(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			8'h6E:   r = {1'b1, 8'd10};  // n
			8'h61:   r = {1'b1, 8'd7};   // a
			8'h76:   r = {1'b1, 8'd11};  // v
			8'h74:   r = {1'b1, 8'd9};   // t
			8'h72:   r = {1'b1, 8'd13};  // r
			8'h5C:   r = {1'b1, 8'd92};  // backslash
			8'h27:   r = {1'b1, 8'd39};  // quote
			8'h22:   r = {1'b1, 8'd34};  // double quote
			8'h62:   r = {1'b1, 8'd8};   // b
			8'h3F:   r = {1'b1, 8'd63};  // question mark
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Hex digit lookup: {hit, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	mode_t      mode_q, mode_d;
	logic [8:0] val_q, val_d;
	logic [1:0] cnt_q, cnt_d;

	logic [7:0] c;
	logic       eos;
	logic       accept;
	logic [8:0] sesc;
	logic [4:0] hexd;
	logic       is_oct;
	logic [8:0] oct_val;
	logic [1:0] cnt_inc;
	logic       emit0, emit1;
	result_t    r0, r1;
	// plain character handling, shared by several modes
	logic       pc_emit;
	result_t    pc_res;
	mode_t      pc_mode;
	// error handling
	result_t    err_res;
	mode_t      err_mode;

	assign c        = item.in_char;
	assign eos      = item.end_of_string;
	assign sesc     = single_escape(c);
	assign hexd     = hex_digit(c);
	assign is_oct   = (c[7:3] == 5'b00110);
	assign oct_val  = {val_q[5:0], 3'b000} + {6'd0, c[2:0]};
	assign cnt_inc  = cnt_q + 2'd1;
	assign err_res  = '{out_byte: 8'd0, is_error: 1'b1, is_last: eos};
	assign err_mode = eos ? MODE_PLAIN : MODE_DISCARD;

	assign item_stall = q_stat.full;
	assign accept     = item_valid && !q_stat.full;

	// Plain text: pass through, or open an escape on backslash
	always_comb begin
		pc_emit = 1'b1;
		pc_res  = '{out_byte: c, is_error: 1'b0, is_last: eos};
		pc_mode = MODE_PLAIN;
		if (c == CH_BSLASH) begin
			if (eos) begin
				pc_res = err_res;
			end else begin
				pc_emit = 1'b0;
				pc_mode = MODE_ESC;
			end
		end
	end

	// Escape state machine: next state and results of this character
	always_comb begin
		mode_d = mode_q;
		val_d  = val_q;
		cnt_d  = cnt_q;
		emit0  = 1'b0;
		emit1  = 1'b0;
		r0     = '0;
		r1     = '0;
		unique case (mode_q)
			MODE_ESC: begin
				if (sesc[8]) begin
					emit0  = 1'b1;
					r0     = '{out_byte: sesc[7:0], is_error: 1'b0, is_last: eos};
					mode_d = MODE_PLAIN;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end else if (is_oct) begin
					if (eos) begin
						emit0  = 1'b1;
						r0     = '{out_byte: {5'd0, c[2:0]}, is_error: 1'b0, is_last: 1'b1};
						mode_d = MODE_PLAIN;
						val_d  = 9'd0;
						cnt_d  = 2'd0;
					end else begin
						mode_d = MODE_OCT;
						val_d  = {6'd0, c[2:0]};
						cnt_d  = 2'd1;
					end
				end else if (c == CH_X && !eos) begin
					mode_d = MODE_HEXF;
				end else begin
					emit0  = 1'b1;
					r0     = err_res;
					mode_d = err_mode;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end
			end
			MODE_OCT: begin
				if (is_oct) begin
					if (oct_val > 9'd255) begin
						emit0  = 1'b1;
						r0     = err_res;
						mode_d = err_mode;
						val_d  = 9'd0;
						cnt_d  = 2'd0;
					end else if (cnt_inc == 2'd3 || eos) begin
						emit0  = 1'b1;
						r0     = '{out_byte: oct_val[7:0], is_error: 1'b0, is_last: eos};
						mode_d = MODE_PLAIN;
						val_d  = 9'd0;
						cnt_d  = 2'd0;
					end else begin
						val_d = oct_val;
						cnt_d = cnt_inc;
					end
				end else begin
					// pending value, then the character itself
					emit0  = 1'b1;
					r0     = '{out_byte: val_q[7:0], is_error: 1'b0, is_last: 1'b0};
					emit1  = pc_emit;
					r1     = pc_res;
					mode_d = pc_mode;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end
			end
			MODE_HEXF: begin
				if (!hexd[4]) begin
					emit0  = 1'b1;
					r0     = err_res;
					mode_d = err_mode;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end else if (eos) begin
					emit0  = 1'b1;
					r0     = '{out_byte: {4'd0, hexd[3:0]}, is_error: 1'b0, is_last: 1'b1};
					mode_d = MODE_PLAIN;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end else begin
					mode_d = MODE_HEX;
					val_d  = {5'd0, hexd[3:0]};
				end
			end
			MODE_HEX: begin
				emit0  = 1'b1;
				val_d  = 9'd0;
				cnt_d  = 2'd0;
				if (hexd[4]) begin
					r0     = '{out_byte: {val_q[3:0], hexd[3:0]}, is_error: 1'b0,
						is_last: eos};
					mode_d = MODE_PLAIN;
				end else begin
					r0     = '{out_byte: val_q[7:0], is_error: 1'b0, is_last: 1'b0};
					emit1  = pc_emit;
					r1     = pc_res;
					mode_d = pc_mode;
				end
			end
			MODE_DISCARD: begin
				if (eos) begin
					emit0  = 1'b1;
					r0     = err_res;
					mode_d = MODE_PLAIN;
					val_d  = 9'd0;
					cnt_d  = 2'd0;
				end
			end
			default: begin
				emit0  = pc_emit;
				r0     = pc_res;
				mode_d = pc_mode;
				val_d  = 9'd0;
				cnt_d  = 2'd0;
			end
		endcase
	end

	// Write request into the queue
	assign q_wr.push        = accept && emit0;
	assign q_wr.entry.two   = emit1;
	assign q_wr.entry.r0    = r0;
	assign q_wr.entry.r1    = r1;

	// State update on each accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			val_q  <= 9'd0;
			cnt_q  <= 2'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			val_q  <= val_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

/* hdl/ced_queue.sv */
// Short FIFO of result entries between the front and back parts.
// Uses ced_pkg for the entry and status types.
module ced_queue #(
	parameter int DEPTH = ced_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ced_pkg::q_wr_t    q_wr,
	input  logic              pop,
	output ced_pkg::entry_t   head,
	output ced_pkg::q_stat_t  q_stat
);
	import ced_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = q_wr.push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = store_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hdl/ced_back.sv */
// Back part: drains queue entries one result per cycle, while the output is not stalled, into the
// output register. Uses ced_pkg for the entry, status and result types.
module ced_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ced_pkg::entry_t   head,
	input  ced_pkg::q_stat_t  q_stat,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_stall,
	output ced_pkg::result_t  res
);
	import ced_pkg::*;

	logic    valid_q;
	logic    sel_q;
	result_t res_q;
	logic    load;
	logic    take;

	// Output register may be refilled when empty or being taken
	assign load = !valid_q || !res_stall;
	assign take = load && !q_stat.empty;
	assign pop  = take && (sel_q || !head.two);

	assign res_valid = valid_q;
	assign res       = res_q;

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= sel_q ? head.r1 : head.r0;
		end
	end

	// Valid flag and second-result select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (take) begin
				sel_q <= !sel_q && head.two;
			end
		end
	end

endmodule

/* hdl/c_escape_sequence_decoder.sv */
// C escape sequence decoder: one literal character per request in, decoded bytes out.
// The first result of an accepted character is written into the queue and then into the output
// register before it shows on res.
// Throughput: one character per cycle while the queue is not full; the output register gives one
// result per cycle while res_stall is low, so a character that yields two results takes it twice.
// Reset (arst_n, asynchronous, active low): plain text mode, queue and output empty.
module c_escape_sequence_decoder #(
	parameter int QUEUE_DEPTH = ced_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ced_pkg::item_t    item,
	output logic              res_valid,
	input  logic              res_stall,
	output ced_pkg::result_t  res
);
	import ced_pkg::*;

	q_wr_t   q_wr;
	q_stat_t q_stat;
	entry_t  head;
	logic    pop;

	// Front: accept and classify
	ced_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.q_stat     (q_stat),
		.item_stall (item_stall),
		.q_wr       (q_wr)
	);

	// Decoupling queue
	ced_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	// Back: deliver results
	ced_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

`ifndef SYNTHESIS
	// The front never requests a write into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_stat.full)
		else $error("queue write while full");

	// The last character of a string always produces a closing result
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.end_of_string) |-> q_wr.push)
		else $error("end of string without a result");

	// Error results carry a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.is_error) |-> (res.out_byte == 8'd0))
		else $error("error result with non-zero byte");

	// When all is idle, a pushed entry reaches the output through the queue and then the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr.push && q_stat.empty && !res_valid) |=> ##1 res_valid)
		else $error("result not delivered after push");
`endif

endmodule
